// ----- rtl/afc_pkg.sv -----
// shared types and constants for the box versus frustum culling block
package afc_pkg;

	// frustum planes and register map
	localparam int NUM_PLANES = 6;
	localparam int NEAR_PLANE = 4;
	localparam int REG_IDX_W  = 3;
	localparam int PADDR_W    = 6;
	localparam int APB_DATA_W = 64;

	localparam logic [REG_IDX_W-1:0] REG_NEAR_BIAS = 3'd6;

	// fixed point field widths
	localparam int COORD_W    = 24;
	localparam int NORM_W     = 12;
	localparam int OFF_W      = 28;
	localparam int BIAS_W     = 8;
	localparam int FRAC_ALIGN = 10;
	localparam int PROD_W     = NORM_W + COORD_W;
	localparam int DIST_W     = 40;
	localparam int PLANE_W    = 64;
	localparam int OFF_LSB    = 36;

	localparam logic [BIAS_W-1:0] NEAR_BIAS_RESET = 8'd13;

	// stream payload widths
	localparam int IN_TDATA_W  = 6 * COORD_W;
	localparam int OUT_TDATA_W = 8;

	typedef enum logic [1:0] {
		VERDICT_OUTSIDE   = 2'd0,
		VERDICT_INSIDE    = 2'd1,
		VERDICT_INTERSECT = 2'd2
	} verdict_t;

	// box bounds, axis 0 is x
	typedef struct packed {
		logic [2:0][COORD_W-1:0] hi;
		logic [2:0][COORD_W-1:0] lo;
	} box_t;

	// per-stage load enables handed to the plane units
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
	} adv_t;

endpackage

// ----- rtl/afc_plane.sv -----
// one plane unit: p/n vertex products, then signed distances and behind flags
module afc_plane (
	input  logic                         clk,
	input  afc_pkg::adv_t                adv,
	input  logic [afc_pkg::PLANE_W-1:0]  plane,
	input  logic [afc_pkg::BIAS_W-1:0]   bias,
	input  afc_pkg::box_t                box_s1,
	output logic                         behind_p_s3,
	output logic                         behind_n_s3
);

	logic signed [afc_pkg::PROD_W-1:0] prod_p_s2 [3];
	logic signed [afc_pkg::PROD_W-1:0] prod_n_s2 [3];
	logic signed [afc_pkg::DIST_W-1:0] dist_p;
	logic signed [afc_pkg::DIST_W-1:0] dist_n;
	logic signed [afc_pkg::DIST_W-1:0] off_ext;
	logic signed [afc_pkg::DIST_W-1:0] bias_ext;
	logic [afc_pkg::OFF_W-1:0]         off;

	// vertex selection by normal sign and the six products
	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			for (int a = 0; a < 3; a++) begin
				logic signed [afc_pkg::NORM_W-1:0]  n;
				logic signed [afc_pkg::COORD_W-1:0] cp;
				logic signed [afc_pkg::COORD_W-1:0] cn;
				n = $signed(plane[a*afc_pkg::NORM_W +: afc_pkg::NORM_W]);
				// strictly positive normal takes the max bound for the p vertex
				if (n > 0) begin
					cp = $signed(box_s1.hi[a]);
					cn = $signed(box_s1.lo[a]);
				end else begin
					cp = $signed(box_s1.lo[a]);
					cn = $signed(box_s1.hi[a]);
				end
				prod_p_s2[a] <= n * cp;
				prod_n_s2[a] <= n * cn;
			end
		end
	end

	// offset and bias aligned to the product scale
	assign off      = plane[afc_pkg::OFF_LSB +: afc_pkg::OFF_W];
	assign off_ext  = $signed({{(afc_pkg::DIST_W-afc_pkg::OFF_W-afc_pkg::FRAC_ALIGN){off[afc_pkg::OFF_W-1]}},
		off, {afc_pkg::FRAC_ALIGN{1'b0}}});
	assign bias_ext = $signed({{(afc_pkg::DIST_W-afc_pkg::BIAS_W-afc_pkg::FRAC_ALIGN){1'b0}},
		bias, {afc_pkg::FRAC_ALIGN{1'b0}}});

	// signed distances of both vertices
	always_comb begin
		dist_p = off_ext + bias_ext;
		dist_n = off_ext;
		for (int a = 0; a < 3; a++) begin
			dist_p = dist_p + afc_pkg::DIST_W'(prod_p_s2[a]);
			dist_n = dist_n + afc_pkg::DIST_W'(prod_n_s2[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s3) begin
			behind_p_s3 <= dist_p[afc_pkg::DIST_W-1];
			behind_n_s3 <= dist_n[afc_pkg::DIST_W-1];
		end
	end

endmodule

// ----- rtl/aabb_frustum_cull_top.sv -----
// Box versus six-plane frustum culling, four-stage pipeline.
// A box taken from the slave stream moves through the s1 input register, the s2 products and
// s3 behind flags into the s4 verdict register on m_tdata. Throughput: one box per cycle unless
// the output stalls; the product stage has 36 parallel 12x24 multipliers feeding a per-plane adder stage.
// Reset: arst_n clears all stage valid bits, plane registers to zero, near bias to 13.
module aabb_frustum_cull_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// min_x, min_y, min_z, max_x, max_y, max_z (24 bits each, lowest first)
	input  logic [afc_pkg::IN_TDATA_W-1:0]    s_tdata,
	// box_valid
	input  logic [0:0]                        s_tuser,
	// master stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// verdict in bits 1:0, rest zero
	output logic [afc_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [afc_pkg::PADDR_W-1:0]       paddr,
	input  logic [afc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [afc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);

	logic [afc_pkg::PLANE_W-1:0] plane_q [afc_pkg::NUM_PLANES];
	logic [afc_pkg::BIAS_W-1:0]  near_bias_q;
	logic [afc_pkg::REG_IDX_W-1:0] cfg_idx;
	logic                          cfg_wr;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic box_valid_s1, box_valid_s2, box_valid_s3;
	afc_pkg::box_t box_s1;
	afc_pkg::verdict_t verdict_s4;
	afc_pkg::verdict_t verdict;
	logic ready_s1, ready_s2, ready_s3, ready_s4;
	afc_pkg::adv_t adv;
	logic [afc_pkg::NUM_PLANES-1:0] behind_p_s3;
	logic [afc_pkg::NUM_PLANES-1:0] behind_n_s3;

	// register write, index from the 8-byte slot
	assign pready  = 1'b1;
	assign cfg_idx = paddr[afc_pkg::PADDR_W-1 -: afc_pkg::REG_IDX_W];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < afc_pkg::NUM_PLANES; i++) begin
				plane_q[i] <= '0;
			end
			near_bias_q <= afc_pkg::NEAR_BIAS_RESET;
		end else if (cfg_wr) begin
			for (int i = 0; i < afc_pkg::NUM_PLANES; i++) begin
				if (cfg_idx == afc_pkg::REG_IDX_W'(i)) begin
					plane_q[i] <= pwdata;
				end
			end
			if (cfg_idx == afc_pkg::REG_NEAR_BIAS) begin
				near_bias_q <= pwdata[afc_pkg::BIAS_W-1:0];
			end
		end
	end

	// register readback
	always_comb begin
		prdata = '0;
		if (cfg_idx < afc_pkg::REG_IDX_W'(afc_pkg::NUM_PLANES)) begin
			prdata = plane_q[cfg_idx];
		end else if (cfg_idx == afc_pkg::REG_NEAR_BIAS) begin
			prdata = afc_pkg::APB_DATA_W'(near_bias_q);
		end
	end

	// stall chain: a stage loads when it is empty or its successor moves
	assign ready_s4  = !valid_s4 || m_tready;
	assign ready_s3  = !valid_s3 || ready_s4;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign s_tready  = ready_s1;
	assign adv.ld_s2 = ready_s2;
	assign adv.ld_s3 = ready_s3;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= s_tvalid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// input capture and box valid flag along the pipe
	always_ff @(posedge clk) begin
		if (ready_s1) begin
			box_valid_s1 <= s_tuser[0];
			box_s1       <= s_tdata;
		end
		if (ready_s2) box_valid_s2 <= box_valid_s1;
		if (ready_s3) box_valid_s3 <= box_valid_s2;
		if (ready_s4) verdict_s4   <= verdict;
	end

	// plane units, bias only on the near plane
	for (genvar p = 0; p < afc_pkg::NUM_PLANES; p++) begin : g_plane
		afc_plane u_plane (
			.clk         (clk),
			.adv         (adv),
			.plane       (plane_q[p]),
			.bias        ((p == afc_pkg::NEAR_PLANE) ? near_bias_q : '0),
			.box_s1      (box_s1),
			.behind_p_s3 (behind_p_s3[p]),
			.behind_n_s3 (behind_n_s3[p])
		);
	end

	// verdict from the behind flags
	always_comb begin
		if (!box_valid_s3 || (|behind_p_s3)) begin
			verdict = afc_pkg::VERDICT_OUTSIDE;
		end else if (|behind_n_s3) begin
			verdict = afc_pkg::VERDICT_INTERSECT;
		end else begin
			verdict = afc_pkg::VERDICT_INSIDE;
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = afc_pkg::OUT_TDATA_W'(verdict_s4);

endmodule

// ----- rtl/afc_checker.sv -----
// port-level checks for the culling block, bound to the top level
module afc_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [afc_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic [0:0]                        s_tuser,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [afc_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// only defined verdict codes leave the block
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:2] == 6'd0) && (m_tdata[1:0] != 2'd3))
		else $error("undefined verdict code");

	// an empty or draining output never backs up the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled while output drains");

	// an invalid box comes out as outside after the pipeline depth
	a_invalid_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tuser[0] && m_tready) ##1 m_tready ##1 m_tready
		##1 m_tready |=> m_tvalid && (m_tdata[1:0] == afc_pkg::VERDICT_OUTSIDE))
		else $error("invalid box not reported outside");

endmodule

bind aabb_frustum_cull_top afc_checker u_afc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
